/* rtl/ddpq_pkg.sv */
// ----------------------------------------------------------------------------
// ddpq_pkg
// Shared types and sizes for the deduplicating dirty-point queue.
// ----------------------------------------------------------------------------
package ddpq_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int CANVAS_W   = 512;
    localparam int CANVAS_H   = 512;

    localparam int COORD_W = 9;
    localparam int FILL_W  = 7;
    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int PT_W    = 2 * COORD_W;

    localparam logic KIND_MARK  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } t_req;

    typedef struct packed {
        logic               found;
        logic               added;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [FILL_W-1:0]  fill_count;
    } t_rsp;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_entry;

    // Control from the sequencer to the cell chain
    typedef struct packed {
        logic shift;
        logic clear;
    } t_chain_ctl;

endpackage

/* rtl/ddpq_ram.sv */
// ----------------------------------------------------------------------------
// ddpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddpq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ddpq_cell.sv */
// ----------------------------------------------------------------------------
// ddpq_cell
// One list entry: takes its neighbor's entry on append, compares the probe.
// ----------------------------------------------------------------------------
module ddpq_cell
    import ddpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_chain_ctl         i_ctl,
    input  t_entry             i_prev,
    input  logic [COORD_W-1:0] i_probe_x,
    input  logic [COORD_W-1:0] i_probe_y,
    output t_entry             o_entry,
    output logic               o_match
);

    logic               r_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_prev.x;
            r_y <= i_prev.y;
        end
    end

    assign o_entry = '{valid: r_valid, x: r_x, y: r_y};
    assign o_match = r_valid && (r_x == i_probe_x) && (r_y == i_probe_y);

endmodule

/* rtl/ddpq_chain.sv */
// ----------------------------------------------------------------------------
// ddpq_chain
// Row of entry cells; a new point enters at the head and the row shifts.
// ----------------------------------------------------------------------------
module ddpq_chain
    import ddpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_chain_ctl         i_ctl,
    input  logic [COORD_W-1:0] i_probe_x,
    input  logic [COORD_W-1:0] i_probe_y,
    output logic               o_hit
);

    t_entry                  w_ent [LIST_DEPTH+1];
    logic [LIST_DEPTH-1:0]   w_match;

    // Head of the chain is the probe point itself
    assign w_ent[0] = '{valid: 1'b1, x: i_probe_x, y: i_probe_y};

    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        ddpq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_prev    (w_ent[k]),
            .i_probe_x (i_probe_x),
            .i_probe_y (i_probe_y),
            .o_entry   (w_ent[k+1]),
            .o_match   (w_match[k])
        );
    end

    assign o_hit = |w_match;

endmodule

/* rtl/dedup_dirty_point_queue_top.sv */
// ----------------------------------------------------------------------------
// dedup_dirty_point_queue_top
// Deduplicating queue of dirty canvas points.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on i_req while busy is low; the request is
//   taken at that edge. A mark request (kind 0) appends its point unless it
//   is off the canvas, already listed (fetched entries included) or the
//   list is full. A fetch request (kind 1) returns the oldest unfetched
//   point; when none is left it reports not-found and empties the list.
//   Exactly one response per request appears on o_rsp for one cycle with
//   o_strobe high, registered after the execute state. The receiver cannot
//   stall; the response must be taken in that cycle.
//   busy is high in the execute state that follows acceptance, so no request is taken
//   while the previous one executes; a new request may be accepted in the same
//   cycle the previous response shows. The execute cycle is set by the
//   parallel compare across the cell row and the registered store read.
//   Reset (synchronous, active low) empties the list; no clearing pass.
// ----------------------------------------------------------------------------
module dedup_dirty_point_queue_top
    import ddpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_strobe, n_strobe;
    t_rsp             r_rsp, n_rsp;

    t_chain_ctl       w_ctl;
    logic             w_hit;
    logic             w_on_canvas;
    logic             w_add;
    logic             w_found;
    logic [PT_W-1:0]  w_rdata;

    ddpq_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_probe_x (r_req.x_coord),
        .i_probe_y (r_req.y_coord),
        .o_hit     (w_hit)
    );

    ddpq_ram #(
        .WIDTH (PT_W),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_add),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_req.x_coord, r_req.y_coord}),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_on_canvas = (32'(r_req.x_coord) < CANVAS_W) && (32'(r_req.y_coord) < CANVAS_H);
    assign w_add   = (r_state == S_EXEC) && (r_req.kind == KIND_MARK) && w_on_canvas
                     && !w_hit && (r_count < CNT_W'(LIST_DEPTH));
    assign w_found = r_rd_idx < r_count;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        w_ctl     = '{shift: 1'b0, clear: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_rsp    = '0;
                if (r_req.kind == KIND_MARK) begin
                    if (w_add) begin
                        w_ctl.shift = 1'b1;
                        n_count     = r_count + 1'b1;
                        n_rsp.added = 1'b1;
                    end
                end else if (w_found) begin
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_rsp.found = 1'b1;
                    n_rsp.out_x = w_rdata[PT_W-1 -: COORD_W];
                    n_rsp.out_y = w_rdata[COORD_W-1:0];
                end else begin
                    // Exhausted: drop the whole list
                    w_ctl.clear = 1'b1;
                    n_count     = '0;
                    n_rd_idx    = '0;
                end
                n_rsp.fill_count = FILL_W'(n_count);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    assign busy     = (r_state == S_EXEC);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

/* rtl/ddpq_checker.sv */
// ----------------------------------------------------------------------------
// ddpq_checker
// Port-level checks of request/response timing for the dirty-point queue.
// ----------------------------------------------------------------------------
module ddpq_checker
    import ddpq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_req i_req,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_rsp
);

    // An accepted request holds busy for exactly one cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // Every request gives one response right after the busy cycle
    a_busy_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("response missing after busy cycle");

    a_found_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_rsp.found && o_rsp.added))
        else $error("response both found and added");

    a_added_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.added |-> o_rsp.fill_count != '0)
        else $error("append reported empty list");

endmodule

bind dedup_dirty_point_queue_top ddpq_checker u_ddpq_checker (.*);

/* bench/ddpq_rsp_checker.sv */
// ----------------------------------------------------------------------------
// ddpq_rsp_checker
// Watches the request and response channels of the dirty-point queue, keeps
// its own copy of the point list and compares every response against it.
// ----------------------------------------------------------------------------
module ddpq_rsp_checker
    import ddpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_strobe,
    input  t_rsp i_rsp,
    output int   o_pending,
    output int   o_fail_count,
    output int   o_requests,
    output int   o_appended,
    output int   o_rejected,
    output int   o_full_drops,
    output int   o_fetched,
    output int   o_exhausted
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PT_W-1:0] listed_pts [LIST_DEPTH];
    int              entries;
    int              next_rd;
    t_rsp            rsp_due [$];
    t_rsp            due;

    int fails;
    int requests;
    int appended;
    int rejected;
    int full_drops;
    int fetched;
    int exhausted;

    initial begin
        entries    = 0;
        next_rd    = 0;
        fails      = 0;
        requests   = 0;
        appended   = 0;
        rejected   = 0;
        full_drops = 0;
        fetched    = 0;
        exhausted  = 0;
    end

    // Apply one request to the local point list and return its response.
    function automatic t_rsp step_point_list(t_req r);
        t_rsp rsp;
        logic hit;
        logic off_canvas;
        rsp = '0;
        if (r.kind == KIND_MARK) begin
            hit = 1'b0;
            for (int k = 0; k < entries; k++) begin
                if (listed_pts[k] == {r.x_coord, r.y_coord})
                    hit = 1'b1;
            end
            off_canvas = (r.x_coord >= CANVAS_W) || (r.y_coord >= CANVAS_H);
            if (entries >= LIST_DEPTH) begin
                full_drops++;
            end else if (hit || off_canvas) begin
                rejected++;
            end else begin
                listed_pts[entries] = {r.x_coord, r.y_coord};
                entries++;
                rsp.added = 1'b1;
                appended++;
            end
        end else begin
            if (next_rd >= entries) begin
                // exhausted: empty the list
                next_rd = 0;
                entries = 0;
                exhausted++;
            end else begin
                rsp.found = 1'b1;
                {rsp.out_x, rsp.out_y} = listed_pts[next_rd];
                next_rd++;
                fetched++;
            end
        end
        rsp.fill_count = FILL_W'(entries);
        return rsp;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fails++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries = 0;
            next_rd = 0;
            rsp_due.delete();
        end else begin
            if (i_strobe !== 1'b0) begin
                if (rsp_due.size() == 0) begin
                    fails++;
                    $error("response strobe with no request outstanding");
                end else begin
                    due = rsp_due.pop_front();
                    check_field("found", due.found, i_rsp.found);
                    check_field("added", due.added, i_rsp.added);
                    check_field("out_x", due.out_x, i_rsp.out_x);
                    check_field("out_y", due.out_y, i_rsp.out_y);
                    check_field("fill_count", due.fill_count, i_rsp.fill_count);
                end
            end
            if (i_start && !i_busy) begin
                rsp_due.push_back(step_point_list(i_req));
                requests++;
            end
        end
        o_pending    <= rsp_due.size();
        o_fail_count <= fails;
        o_requests   <= requests;
        o_appended   <= appended;
        o_rejected   <= rejected;
        o_full_drops <= full_drops;
        o_fetched    <= fetched;
        o_exhausted  <= exhausted;
    end

endmodule

/* bench/dedup_dirty_point_queue_top_test.sv */
// ----------------------------------------------------------------------------
// dedup_dirty_point_queue_top_test
// Drives mark and fetch requests into the dirty-point queue: a directed
// opening over the corner points, duplicates and empty-list fetches, then
// random bursts of marks, fetches and full-list fills with random idle gaps.
// ----------------------------------------------------------------------------
module dedup_dirty_point_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ddpq_pkg::*;

    localparam int RANDOM_REQS = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req req_in  = '0;
    logic busy;
    logic o_strobe;
    t_rsp rsp_out;

    int pending;
    int fail_count;
    int requests;
    int appended;
    int rejected;
    int full_drops;
    int fetched;
    int exhausted;

    int sent = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    dedup_dirty_point_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req_in),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_rsp   (rsp_out)
    );

    ddpq_rsp_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req_in),
        .i_strobe    (o_strobe),
        .i_rsp       (rsp_out),
        .o_pending   (pending),
        .o_fail_count(fail_count),
        .o_requests  (requests),
        .o_appended  (appended),
        .o_rejected  (rejected),
        .o_full_drops(full_drops),
        .o_fetched   (fetched),
        .o_exhausted (exhausted)
    );

    function automatic t_req mark_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        t_req r;
        r.kind    = KIND_MARK;
        r.x_coord = x;
        r.y_coord = y;
        return r;
    endfunction

    // coordinates on a fetch are don't-care; randomize them anyway
    function automatic t_req fetch_req();
        t_req r;
        r.kind    = KIND_FETCH;
        r.x_coord = COORD_W'($urandom);
        r.y_coord = COORD_W'($urandom);
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] any_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // small pool so duplicates are frequent
    function automatic t_req pool_mark(int wide_pct);
        if ($urandom_range(0, 99) < wide_pct)
            return mark_at(any_coord(), any_coord());
        return mark_at(COORD_W'($urandom_range(0, 9)), COORD_W'($urandom_range(0, 9)));
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Hold the request until it is taken.
    task automatic send(t_req r, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        req_in <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        bit calm;
        bit pressed;
        int mode;
        int len;

        pressed = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        send(fetch_req(), 0);                       // empty list
        send(mark_at('0, '0), 0);
        send(mark_at('1, '1), 0);
        send(mark_at('1, '0), 3);
        send(mark_at('0, '1), 0);
        send(mark_at('0, '0), 0);                   // duplicate, unfetched
        send(fetch_req(), 1);
        send(fetch_req(), 0);
        send(mark_at('0, '0), 0);                   // duplicate, already fetched
        send(mark_at('1, '1), 2);
        send(mark_at(9'd5, 9'd7), 0);
        send(fetch_req(), 0);
        send(fetch_req(), 0);
        send(fetch_req(), 5);
        send(fetch_req(), 0);                       // exhausted, clears list
        send(fetch_req(), 0);
        send(mark_at('0, '0), 0);                   // accepted again after clear
        send(fetch_req(), 0);
        send(fetch_req(), 0);
        drain();

        while (sent < RANDOM_REQS) begin
            calm = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 40);
            case (mode)
                0: repeat (len) send(pool_mark(25), draw_gap(calm));
                1: repeat (len) send(fetch_req(), draw_gap(calm));
                2: repeat (len) begin
                    if ($urandom_range(0, 9) < 6)
                        send(pool_mark(25), draw_gap(calm));
                    else
                        send(fetch_req(), draw_gap(calm));
                end
                default: begin
                    // overfill the list, then drain it past empty
                    repeat ($urandom_range(60, 72))
                        send(mark_at(any_coord(), any_coord()), draw_gap(calm));
                    repeat ($urandom_range(60, 70))
                        send(fetch_req(), draw_gap(calm));
                end
            endcase
            if (!pressed && sent >= RANDOM_REQS / 2) begin
                drain();
                pressed = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests: %0d appended, %0d duplicate drops, %0d full-list drops",
                 requests, appended, rejected, full_drops);
        $display("%0d points fetched, %0d fetches on an exhausted list", fetched, exhausted);
        if (fail_count == 0)
            $display("dedup_dirty_point_queue_top_test passed");
        else
            $display("dedup_dirty_point_queue_top_test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("dedup_dirty_point_queue_top_test failed");
        $finish;
    end

endmodule
